// ===== sv/sbrs_pkg.sv =====
// Shared types, constants and the bit error rate table for the rate selector.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package sbrs_pkg;

    // Field and port widths
    localparam int SNR_BITS        = 11;
    localparam int LEN_FIELD_BITS  = 12;
    localparam int LINK_MBPS_BITS  = 6;
    localparam int RATE_CODE_BITS  = 3;
    localparam int S_TDATA_BITS    = 24;
    localparam int M_TDATA_BITS    = 16;
    localparam int CUTOFF_BITS     = 32;
    localparam int CFG_INDEX_BITS  = 2;

    // Parameter defaults and limits
    localparam int LENGTH_BITS_DEF       = 12;
    localparam int BER_FRACTION_BITS_DEF = 32;
    localparam int BER_FRAC_MAX          = 48;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_ERROR_CUTOFF     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_USE_PACKET_ERROR = 2'd1;

    localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = 32'd4294967;

    // Table geometry: rows every 5 dB (80 sixteenths), 0..30 dB
    localparam int SNR_ROWS    = 7;
    localparam int RATE_COLS   = 8;
    localparam int SNR_MAX_Q4  = 480;
    localparam int SNR_STEP_Q4 = 80;

    // Arithmetic unit geometry
    localparam int MUL_CHUNK_BITS = 17;
    localparam int DIV_DIGIT_BITS = 8;

    localparam logic [127:0] DEC_SCALE = 128'd100000000;

    // Bit error rates in units of 1e-8, one row per SNR step, one column per rate
    localparam logic [31:0] BER_DEC [SNR_ROWS][RATE_COLS] = '{
        '{32'd2840000, 32'd7400000, 32'd17400000, 32'd29100000,
          32'd34700000, 32'd47500000, 32'd49700000, 32'd50200000},
        '{32'd468000, 32'd5630000, 32'd14100000, 32'd27400000,
          32'd33700000, 32'd46900000, 32'd49500000, 32'd49700000},
        '{32'd438, 32'd146000, 32'd6820000, 32'd433000,
          32'd17600000, 32'd46500000, 32'd49500000, 32'd49600000},
        '{32'd0, 32'd7530, 32'd2810000, 32'd0,
          32'd14800, 32'd5860000, 32'd43700000, 32'd43700000},
        '{32'd0, 32'd0, 32'd1000000, 32'd0,
          32'd0, 32'd227000, 32'd2630000, 32'd8380000},
        '{32'd0, 32'd0, 32'd337000, 32'd0,
          32'd0, 32'd0, 32'd0, 32'd2500},
        '{32'd0, 32'd0, 32'd315000, 32'd0,
          32'd0, 32'd0, 32'd0, 32'd0}
    };

    localparam logic [LINK_MBPS_BITS-1:0] LINK_MBPS [RATE_COLS] = '{
        6'd6, 6'd9, 6'd12, 6'd18, 6'd24, 6'd36, 6'd48, 6'd54
    };

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROM,
        ST_PROD,
        ST_DIV,
        ST_BER,
        ST_POW_INIT,
        ST_POW_BIT,
        ST_MUL_STEP,
        ST_MUL_WB,
        ST_PER,
        ST_CMP,
        ST_EMIT
    } t_state;

    // Datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_ROM,
        DP_PROD,
        DP_DIV,
        DP_BER,
        DP_POW_INIT,
        DP_SQ_LOAD,
        DP_BS_LOAD,
        DP_BSR_COPY,
        DP_MUL_STEP,
        DP_MUL_WB,
        DP_PER
    } t_dp_op;

    typedef struct packed {
        t_dp_op                    op;
        logic [RATE_CODE_BITS-1:0] col;
    } t_dp_cmd;

    typedef struct packed {
        logic acc_one;   // power accumulator holds exactly one
        logic len_bit;   // selected exponent bit
        logic pass;      // current error rate within cutoff
    } t_dp_status;

    // Table entry in Q0.fbits, rounded to nearest with ties up; elaboration only
    function automatic logic [BER_FRAC_MAX-1:0] ber_rom_q(input int row, input int col,
                                                          input int fbits);
        logic [127:0] num;
        logic [127:0] quo;
        num = 128'(BER_DEC[row][col]) << (fbits + 1);
        quo = ((num / DEC_SCALE) + 128'd1) >> 1;
        return quo[BER_FRAC_MAX-1:0];
    endfunction

endpackage

// ===== sv/snr_ber_rate_selector.sv =====
// Rate selector: for each item, tests rates from the highest rate code down to code 1 and emits
// the first that meets the cutoff, else code 0. Each rate tested takes a table read, a product,
// the divide by 80 and, in packet error mode, 1 - (1 - BER)^length by square and multiply.
// Up to 7 rates are tested, in bit error mode and in packet error mode.
// One item at a time, through a 17-bit chunked multiplier and an 8-bit-per-cycle divider.
// Synchronous active-low reset clears control state and restores the register defaults.
`timescale 1ns / 1ps

module snr_ber_rate_selector #(
    parameter int LENGTH_BITS       = sbrs_pkg::LENGTH_BITS_DEF,
    parameter int BER_FRACTION_BITS = sbrs_pkg::BER_FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sbrs_pkg::S_TDATA_BITS-1:0]   s_tdata,   // [10:0] snr_q4, [22:11] frame_length
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sbrs_pkg::M_TDATA_BITS-1:0]   m_tdata,   // [5:0] link_mbps, [8:6] rate_code
    // Register write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sbrs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [sbrs_pkg::CUTOFF_BITS-1:0]    i_cfg_data
);
    import sbrs_pkg::*;

    localparam int BIT_W   = $clog2(LENGTH_BITS);
    localparam int PAD_OUT = M_TDATA_BITS - LINK_MBPS_BITS - RATE_CODE_BITS;

    // Configuration registers; writes are always taken, unknown indexes dropped
    logic [CUTOFF_BITS-1:0] r_error_cutoff;
    logic                   r_use_packet_error;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_cutoff     <= CUTOFF_RESET;
            r_use_packet_error <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ERROR_CUTOFF:     r_error_cutoff     <= i_cfg_data;
                REG_USE_PACKET_ERROR: r_use_packet_error <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Unpack request fields
    logic signed [SNR_BITS-1:0] w_snr_q4;
    logic [LEN_FIELD_BITS-1:0]  w_frame_length;

    assign w_snr_q4       = s_tdata[SNR_BITS-1:0];
    assign w_frame_length = s_tdata[SNR_BITS +: LEN_FIELD_BITS];

    // Controller and datapath
    t_dp_cmd                   w_cmd;
    t_dp_status                w_status;
    logic [BIT_W-1:0]          w_bit_idx;
    logic                      w_in_accept;
    logic                      w_out_free;
    logic                      w_out_load;
    logic [RATE_CODE_BITS-1:0] w_code;

    assign w_in_accept = s_tvalid && s_tready;

    sbrs_ctrl #(
        .LENGTH_BITS       (LENGTH_BITS),
        .BER_FRACTION_BITS (BER_FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .o_in_ready  (s_tready),
        .i_use_per   (r_use_packet_error),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_bit_idx   (w_bit_idx),
        .i_out_free  (w_out_free),
        .o_out_load  (w_out_load),
        .o_code      (w_code)
    );

    sbrs_dp #(
        .LENGTH_BITS       (LENGTH_BITS),
        .BER_FRACTION_BITS (BER_FRACTION_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_bit_idx      (w_bit_idx),
        .i_snr_q4       (w_snr_q4),
        .i_frame_length (w_frame_length),
        .i_error_cutoff (r_error_cutoff),
        .o_status       (w_status)
    );

    // Output register: hold the result until the downstream transaction completes
    logic                      r_m_tvalid;
    logic [RATE_CODE_BITS-1:0] r_rate_code;

    assign w_out_free = !r_m_tvalid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_rate_code <= w_code;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {{PAD_OUT{1'b0}}, r_rate_code, LINK_MBPS[r_rate_code]};

endmodule

// ===== sv/sbrs_ctrl.sv =====
// Sequencing state machine of the rate selector: steps the datapath through
// interpolation, packet error power (in packet error mode) and comparison for each rate. Uses sbrs_pkg.
`timescale 1ns / 1ps

module sbrs_ctrl #(
    parameter int LENGTH_BITS       = sbrs_pkg::LENGTH_BITS_DEF,
    parameter int BER_FRACTION_BITS = sbrs_pkg::BER_FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_accept,
    output logic                                o_in_ready,
    input  logic                                i_use_per,
    input  sbrs_pkg::t_dp_status                i_status,
    output sbrs_pkg::t_dp_cmd                   o_cmd,
    output logic [$clog2(LENGTH_BITS)-1:0]      o_bit_idx,
    input  logic                                i_out_free,
    output logic                                o_out_load,
    output logic [sbrs_pkg::RATE_CODE_BITS-1:0] o_code
);
    import sbrs_pkg::*;

    localparam int BIT_W     = $clog2(LENGTH_BITS);
    localparam int AW        = BER_FRACTION_BITS + 1;
    localparam int DIV_STEPS = (BER_FRACTION_BITS + 7 + DIV_DIGIT_BITS - 1) / DIV_DIGIT_BITS;
    localparam int NCH       = (AW + MUL_CHUNK_BITS - 1) / MUL_CHUNK_BITS;
    localparam int CNT_MAX   = (DIV_STEPS > NCH) ? DIV_STEPS : NCH;
    localparam int CNT_W     = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

    t_state                    r_state, n_state;
    logic [RATE_CODE_BITS-1:0] r_col, n_col;
    logic [RATE_CODE_BITS-1:0] r_code, n_code;
    logic [BIT_W-1:0]          r_bit, n_bit;
    logic                      r_phase, n_phase;   // 0 square, 1 multiply
    logic [CNT_W-1:0]          r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_code  <= '0;
            r_bit   <= '0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_code  <= n_code;
            r_bit   <= n_bit;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and counters
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_code  = r_code;
        n_bit   = r_bit;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_accept) begin
                    n_state = ST_ROM;
                    n_col   = RATE_CODE_BITS'(RATE_COLS - 1);
                end
            end
            ST_ROM:  n_state = ST_PROD;
            ST_PROD: begin
                n_state = ST_DIV;
                n_cnt   = '0;
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_BER;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_BER:  n_state = i_use_per ? ST_POW_INIT : ST_CMP;
            ST_POW_INIT: begin
                n_state = ST_POW_BIT;
                n_bit   = BIT_W'(LENGTH_BITS - 1);
                n_phase = 1'b0;
            end
            ST_POW_BIT: begin
                if (!r_phase) begin
                    if (i_status.acc_one) begin
                        n_phase = 1'b1;
                    end else begin
                        n_state = ST_MUL_STEP;
                        n_cnt   = '0;
                    end
                end else if (i_status.len_bit && !i_status.acc_one) begin
                    n_state = ST_MUL_STEP;
                    n_cnt   = '0;
                end else if (r_bit == '0) begin
                    n_state = ST_PER;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_phase = 1'b0;
                end
            end
            ST_MUL_STEP: begin
                if (r_cnt == CNT_W'(NCH - 1)) begin
                    n_state = ST_MUL_WB;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MUL_WB: begin
                n_state = ST_POW_BIT;
                if (!r_phase) begin
                    n_phase = 1'b1;
                end else if (r_bit == '0) begin
                    n_state = ST_PER;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_phase = 1'b0;
                end
            end
            ST_PER:  n_state = ST_CMP;
            ST_CMP: begin
                if (i_status.pass) begin
                    n_code  = r_col;
                    n_state = ST_EMIT;
                end else if (r_col == RATE_CODE_BITS'(1)) begin
                    n_code  = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_col   = r_col - 1'b1;
                    n_state = ST_ROM;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands and handshake outputs
    always_comb begin
        o_cmd.op   = DP_NOP;
        o_cmd.col  = r_col;
        o_out_load = 1'b0;
        o_in_ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE:     o_cmd.op = i_in_accept ? DP_LOAD : DP_NOP;
            ST_ROM:      o_cmd.op = DP_ROM;
            ST_PROD:     o_cmd.op = DP_PROD;
            ST_DIV:      o_cmd.op = DP_DIV;
            ST_BER:      o_cmd.op = DP_BER;
            ST_POW_INIT: o_cmd.op = DP_POW_INIT;
            ST_POW_BIT: begin
                if (!r_phase) begin
                    o_cmd.op = i_status.acc_one ? DP_NOP : DP_SQ_LOAD;
                end else if (i_status.len_bit) begin
                    o_cmd.op = i_status.acc_one ? DP_BSR_COPY : DP_BS_LOAD;
                end
            end
            ST_MUL_STEP: o_cmd.op = DP_MUL_STEP;
            ST_MUL_WB:   o_cmd.op = DP_MUL_WB;
            ST_PER:      o_cmd.op = DP_PER;
            ST_CMP:      o_cmd.op = DP_NOP;
            ST_EMIT:     o_out_load = i_out_free;
            default:     o_cmd.op = DP_NOP;
        endcase
    end

    assign o_bit_idx = r_bit;
    assign o_code    = r_code;

endmodule

// ===== sv/sbrs_dp.sv =====
// Datapath of the rate selector: table interpolation, divide by 80, chunked
// fixed-point multiplier and cutoff compare. Uses sbrs_pkg; driven by sbrs_ctrl.
`timescale 1ns / 1ps

module sbrs_dp #(
    parameter int LENGTH_BITS       = sbrs_pkg::LENGTH_BITS_DEF,
    parameter int BER_FRACTION_BITS = sbrs_pkg::BER_FRACTION_BITS_DEF
) (
    input  logic                                    i_clk,
    input  sbrs_pkg::t_dp_cmd                       i_cmd,
    input  logic [$clog2(LENGTH_BITS)-1:0]          i_bit_idx,
    input  logic signed [sbrs_pkg::SNR_BITS-1:0]    i_snr_q4,
    input  logic [sbrs_pkg::LEN_FIELD_BITS-1:0]     i_frame_length,
    input  logic [sbrs_pkg::CUTOFF_BITS-1:0]        i_error_cutoff,
    output sbrs_pkg::t_dp_status                    o_status
);
    import sbrs_pkg::*;

    localparam int F         = BER_FRACTION_BITS;
    localparam int AW        = F + 1;
    localparam int LB        = LENGTH_BITS;
    localparam int FRAC_BITS = 7;
    localparam int SEG_BITS  = 3;
    localparam int S_BITS    = 9;
    localparam int DIV_STEPS = (F + FRAC_BITS + DIV_DIGIT_BITS - 1) / DIV_DIGIT_BITS;
    localparam int PW        = DIV_STEPS * DIV_DIGIT_BITS;
    localparam int CW        = MUL_CHUNK_BITS;
    localparam int NCH       = (AW + CW - 1) / CW;
    localparam int MBW       = NCH * CW;
    localparam int PRW       = AW + MBW;
    localparam int ALIGN_W   = ((F >= CUTOFF_BITS) ? F : CUTOFF_BITS) + 1;
    localparam int SH_E      = (F >= CUTOFF_BITS) ? 0 : CUTOFF_BITS - F;
    localparam int SH_C      = (F >= CUTOFF_BITS) ? F - CUTOFF_BITS : 0;

    localparam logic [AW-1:0] ONE = AW'(1) << F;

    // Constant table in Q0.F
    logic [F-1:0] w_rom [SNR_ROWS][RATE_COLS];

    for (genvar gr = 0; gr < SNR_ROWS; gr++) begin : g_row
        for (genvar gc = 0; gc < RATE_COLS; gc++) begin : g_col
            assign w_rom[gr][gc] = F'(ber_rom_q(gr, gc, F));
        end
    end

    logic [SEG_BITS-1:0]  r_seg;
    logic [FRAC_BITS-1:0] r_frac;
    logic [LB-1:0]        r_len;
    logic [F-1:0]         r_lo, r_hi;
    logic                 r_up;
    logic [PW-1:0]        r_dnum;
    logic [FRAC_BITS-1:0] r_drem;
    logic [AW-1:0]        r_err, r_bsr, r_acc, r_ma;
    logic [MBW-1:0]       r_mb;
    logic [PRW-1:0]       r_prod;

    // Clamp to 0..30 dB and split into table row and position within the step
    logic [S_BITS-1:0]    w_s;
    logic [SEG_BITS-1:0]  w_seg;
    logic [S_BITS-1:0]    w_frac_full;
    logic [LB-1:0]        w_len;

    always_comb begin
        if (i_snr_q4[SNR_BITS-1]) begin
            w_s = '0;
        end else if (i_snr_q4[SNR_BITS-2:0] >= (SNR_BITS-1)'(SNR_MAX_Q4)) begin
            w_s = S_BITS'(SNR_MAX_Q4);
        end else begin
            w_s = i_snr_q4[S_BITS-1:0];
        end
        w_seg = '0;
        for (int k = 1; k < SNR_ROWS; k++) begin
            if (w_s >= S_BITS'(k * SNR_STEP_Q4)) begin
                w_seg = SEG_BITS'(k);
            end
        end
        w_frac_full = w_s - (S_BITS'(w_seg) * S_BITS'(SNR_STEP_Q4));
    end

    for (genvar gl = 0; gl < LB; gl++) begin : g_len
        if (gl < LEN_FIELD_BITS) begin : g_take
            assign w_len[gl] = i_frame_length[gl];
        end else begin : g_zero
            assign w_len[gl] = 1'b0;
        end
    end

    // Table reads for the bracketing rows
    logic [SEG_BITS-1:0] w_row_hi;
    logic [F-1:0]        w_rd_lo, w_rd_hi;

    assign w_row_hi = (r_seg == SEG_BITS'(SNR_ROWS - 1)) ? r_seg : r_seg + 1'b1;
    assign w_rd_lo  = w_rom[r_seg][i_cmd.col];
    assign w_rd_hi  = w_rom[w_row_hi][i_cmd.col];

    // Slope magnitude times position
    logic [F-1:0] w_diff;
    assign w_diff = r_up ? (r_hi - r_lo) : (r_lo - r_hi);

    // One digit of the divide by 80: shift numerator bits into a narrow remainder
    logic [PW-1:0]        w_dnum;
    logic [FRAC_BITS:0]   w_drem;

    always_comb begin
        w_dnum = r_dnum;
        w_drem = {1'b0, r_drem};
        for (int j = 0; j < DIV_DIGIT_BITS; j++) begin
            w_drem = {w_drem[FRAC_BITS-1:0], w_dnum[PW-1]};
            w_dnum = {w_dnum[PW-2:0], 1'b0};
            if (w_drem >= (FRAC_BITS+1)'(SNR_STEP_Q4)) begin
                w_drem    = w_drem - (FRAC_BITS+1)'(SNR_STEP_Q4);
                w_dnum[0] = 1'b1;
            end
        end
    end

    // Partial product of the chunked multiplier, top chunk first
    logic [AW+CW-1:0] w_pp;
    assign w_pp = r_ma * r_mb[MBW-1 -: CW];

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_NOP: begin
            end
            DP_LOAD: begin
                r_seg  <= w_seg;
                r_frac <= w_frac_full[FRAC_BITS-1:0];
                r_len  <= w_len;
            end
            DP_ROM: begin
                r_lo <= w_rd_lo;
                r_hi <= w_rd_hi;
                r_up <= (w_rd_hi >= w_rd_lo);
            end
            DP_PROD: begin
                r_dnum <= PW'(w_diff * r_frac);
                r_drem <= '0;
            end
            DP_DIV: begin
                r_dnum <= w_dnum;
                r_drem <= w_drem[FRAC_BITS-1:0];
            end
            DP_BER: begin
                r_err <= r_up ? (AW'(r_lo) + AW'(r_dnum[F-1:0]))
                              : (AW'(r_lo) - AW'(r_dnum[F-1:0]));
            end
            DP_POW_INIT: begin
                r_acc <= ONE;
                r_bsr <= ONE - r_err;
            end
            DP_SQ_LOAD: begin
                r_ma   <= r_acc;
                r_mb   <= MBW'(r_acc);
                r_prod <= '0;
            end
            DP_BS_LOAD: begin
                r_ma   <= r_acc;
                r_mb   <= MBW'(r_bsr);
                r_prod <= '0;
            end
            DP_BSR_COPY: begin
                r_acc <= r_bsr;
            end
            DP_MUL_STEP: begin
                r_prod <= (r_prod << CW) + PRW'(w_pp);
                r_mb   <= r_mb << CW;
            end
            DP_MUL_WB: begin
                r_acc <= r_prod[F +: AW];
            end
            DP_PER: begin
                r_err <= ONE - r_acc;
            end
            default: begin
            end
        endcase
    end

    // Status back to the controller
    logic [ALIGN_W-1:0] w_err_al, w_cut_al;

    assign w_err_al         = ALIGN_W'(r_err) << SH_E;
    assign w_cut_al         = ALIGN_W'(i_error_cutoff) << SH_C;
    assign o_status.acc_one = (r_acc == ONE);
    assign o_status.len_bit = r_len[i_bit_idx];
    assign o_status.pass    = (w_err_al <= w_cut_al);

endmodule
